>>> src/ifs_pkg.sv
package ifs_pkg;

  // point format: signed Q7.16 in 24 bits
  localparam int P_W    = 24;
  localparam int COEF_W = 18;
  localparam int PROD_W = P_W + COEF_W;
  localparam int SUM_W  = PROD_W + 1;

  typedef logic signed [P_W-1:0]    point_t;
  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  // opcodes
  localparam logic OP_ITER = 1'b0;
  localparam logic OP_READ = 1'b1;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_STEM  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT = 2'd2;

  typedef struct packed {
    logic [6:0] stem;
    logic [6:0] left;
    logic [6:0] right;
  } ifs_thr_t;

  localparam logic [6:0] THR_STEM_RST  = 7'd1;
  localparam logic [6:0] THR_LEFT_RST  = 7'd8;
  localparam logic [6:0] THR_RIGHT_RST = 7'd15;

  // affine maps, coefficients in Q16, order a b e c d f
  typedef enum logic [1:0] {
    MAP_STEM,
    MAP_LEFT,
    MAP_RIGHT,
    MAP_MAIN
  } ifs_map_e;

  localparam int K_A = 0;
  localparam int K_B = 1;
  localparam int K_E = 2;
  localparam int K_C = 3;
  localparam int K_D = 4;
  localparam int K_F = 5;

  localparam coef_t FERN_MAPS [4][6] = '{
    '{ 18'sd0,      18'sd0,      18'sd0, 18'sd0,      18'sd10486, 18'sd0      },
    '{ 18'sd13107, -18'sd17039,  18'sd0, 18'sd15073,  18'sd14418, 18'sd104858 },
    '{-18'sd9830,   18'sd18350,  18'sd0, 18'sd17039,  18'sd15729, 18'sd28836  },
    '{ 18'sd55706,  18'sd2621,   18'sd0, -18'sd2621,  18'sd55706, 18'sd104858 }
  };

  // scaling: col = W * (x + 2.75) / 5.5, row = H * (10.1 - y) / 10.1
  localparam logic signed [P_W:0]   COL_OFFSET = 25'sd180224;
  localparam logic signed [P_W+4:0] ROW_TOP    = 29'sd6619136;
  localparam logic signed [P_W+4:0] Y_GAIN     = 29'sd10;

  // 5.5 in Q16 = 2^15 * 11, 10.1 in Q16 times ten = 2^16 * 101
  localparam int COL_PRE_SH  = 15;
  localparam int ROW_PRE_SH  = 16;
  localparam int REC_COL_W   = 20;
  localparam int REC_ROW_W   = 24;
  localparam int REC_COL_SH  = 23;
  localparam int REC_ROW_SH  = 30;
  localparam logic [REC_COL_W-1:0] REC_COL = 20'd762601;
  localparam logic [REC_ROW_W-1:0] REC_ROW = 24'd10631108;

  // controller states
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_AX,
    S_BY,
    S_CX,
    S_DY,
    S_NY,
    S_SCALE,
    S_DIV,
    S_PLOT,
    S_RD_ADDR,
    S_RD_DATA,
    S_DONE
  } ifs_state_e;

  // datapath steps
  typedef enum logic [3:0] {
    STEP_NONE,
    STEP_AX,
    STEP_BY,
    STEP_CX,
    STEP_DY,
    STEP_NY,
    STEP_SCALE,
    STEP_DIV,
    STEP_PLOT,
    STEP_RD_ADDR,
    STEP_RD_DATA
  } ifs_step_e;

  typedef struct packed {
    logic      clear;
    logic      load;
    ifs_step_e step;
  } ifs_cmd_t;

  typedef struct packed {
    logic clear_last;
  } ifs_status_t;

endpackage

>>> src/ifs_ram.sv
module ifs_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 32768
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // single port, registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/ifs_ctrl.sv
module ifs_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 opcode_i,
  output logic                 busy_o,
  output logic                 result_valid_o,
  output ifs_pkg::ifs_cmd_t    cmd_o,
  input  ifs_pkg::ifs_status_t status_i
);
  import ifs_pkg::*;

  ifs_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d        = state_q;
    cmd_o.clear    = 1'b0;
    cmd_o.load     = 1'b0;
    cmd_o.step     = STEP_NONE;
    busy_o         = 1'b1;
    result_valid_o = 1'b0;
    unique case (state_q) inside
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (status_i.clear_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE, S_DONE: begin
        busy_o         = 1'b0;
        result_valid_o = (state_q == S_DONE);
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = (opcode_i == OP_READ) ? S_RD_ADDR : S_AX;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_AX: begin
        cmd_o.step = STEP_AX;
        state_d    = S_BY;
      end
      S_BY: begin
        cmd_o.step = STEP_BY;
        state_d    = S_CX;
      end
      S_CX: begin
        cmd_o.step = STEP_CX;
        state_d    = S_DY;
      end
      S_DY: begin
        cmd_o.step = STEP_DY;
        state_d    = S_NY;
      end
      S_NY: begin
        cmd_o.step = STEP_NY;
        state_d    = S_SCALE;
      end
      S_SCALE: begin
        cmd_o.step = STEP_SCALE;
        state_d    = S_DIV;
      end
      S_DIV: begin
        cmd_o.step = STEP_DIV;
        state_d    = S_PLOT;
      end
      S_PLOT: begin
        cmd_o.step = STEP_PLOT;
        state_d    = S_DONE;
      end
      S_RD_ADDR: begin
        cmd_o.step = STEP_RD_ADDR;
        state_d    = S_RD_DATA;
      end
      S_RD_DATA: begin
        cmd_o.step = STEP_RD_DATA;
        state_d    = S_DONE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // a result beat only follows the last step of an item
  a_done_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> ($past(state_q) == S_PLOT || $past(state_q) == S_RD_DATA))
    else $error("result beat without finished work");

  // an accepted read goes straight to the memory access
  a_read_dispatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && opcode_i == OP_READ) |=> state_q == S_RD_ADDR)
    else $error("read not dispatched");

  // the clearing pass runs to its last entry
  a_clear_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR && !status_i.clear_last) |=> state_q == S_CLEAR)
    else $error("clearing pass left early");

endmodule

>>> src/ifs_dp.sv
module ifs_dp #(
  parameter int IMAGE_WIDTH  = 256,
  parameter int IMAGE_HEIGHT = 128
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ifs_pkg::ifs_cmd_t    cmd_i,
  output ifs_pkg::ifs_status_t status_o,
  input  ifs_pkg::ifs_thr_t    thr_i,
  input  logic [6:0]           rand_value_i,
  input  logic [6:0]           read_row_i,
  input  logic [7:0]           read_col_i,
  output logic [7:0]           plot_col_o,
  output logic [6:0]           plot_row_o,
  output logic                 plotted_o,
  output logic                 pixel_bit_o
);
  import ifs_pkg::*;

  localparam int DEPTH   = IMAGE_WIDTH * IMAGE_HEIGHT;
  localparam int AW      = $clog2(DEPTH);
  localparam int CW_W    = $clog2(IMAGE_WIDTH + 1);
  localparam int RH_W    = $clog2(IMAGE_HEIGHT + 1);
  localparam int CPROD_W = CW_W + P_W;
  localparam int CQ_W    = CPROD_W - COL_PRE_SH;
  localparam int CM_W    = CQ_W + REC_COL_W;
  localparam int COLV_W  = CM_W - REC_COL_SH;
  localparam int RPROD_W = RH_W + P_W + 3;
  localparam int RQ_W    = RPROD_W - ROW_PRE_SH;
  localparam int RM_W    = RQ_W + REC_ROW_W;
  localparam int ROWV_W  = RM_W - REC_ROW_SH;
  localparam int V_W     = SUM_W - 15;

  // round half up to Q16, add offset, saturate to 24 bits
  function automatic point_t round_sat(input sum_t s, input coef_t off);
    sum_t                  r;
    logic signed [V_W-2:0] q;
    logic signed [V_W-1:0] v;
    r = s + SUM_W'(32768);
    q = r[SUM_W-1:16];
    v = V_W'(q) + V_W'(off);
    if (v[V_W-1:P_W-1] == '0 || v[V_W-1:P_W-1] == '1) begin
      return v[P_W-1:0];
    end else if (v[V_W-1]) begin
      return {1'b1, {(P_W-1){1'b0}}};
    end else begin
      return {1'b0, {(P_W-1){1'b1}}};
    end
  endfunction

  // map choice from the thresholds, compared in order
  function automatic ifs_map_e pick_map(input logic [6:0] r, input ifs_thr_t t);
    if (r < t.stem) begin
      return MAP_STEM;
    end else if (r < t.left) begin
      return MAP_LEFT;
    end else if (r < t.right) begin
      return MAP_RIGHT;
    end else begin
      return MAP_MAIN;
    end
  endfunction

  point_t              x_q, x_d, y_q, y_d, nx_q, nx_d;
  prod_t               prod_q, prod_d, acc_q, acc_d;
  ifs_map_e            map_q, map_d;
  logic [6:0]          rd_row_q, rd_row_d;
  logic [7:0]          rd_col_q, rd_col_d;
  logic                rd_ok_q, rd_ok_d;
  logic                c_neg_q, c_neg_d, r_neg_q, r_neg_d;
  logic [CPROD_W-1:0]  c_prod_q, c_prod_d;
  logic [RPROD_W-1:0]  r_prod_q, r_prod_d;
  logic [CM_W-1:0]     c_mul_q, c_mul_d;
  logic [RM_W-1:0]     r_mul_q, r_mul_d;
  logic [AW-1:0]       clr_cnt_q, clr_cnt_d;
  logic [7:0]          plot_col_q, plot_col_d;
  logic [6:0]          plot_row_q, plot_row_d;
  logic                plotted_q, plotted_d;
  logic                pixel_bit_q, pixel_bit_d;

  coef_t               mul_coef;
  point_t              mul_opnd;
  prod_t               mul_p;
  sum_t                sum;
  logic signed [P_W:0]   cx;
  logic signed [P_W+4:0] ry;
  logic [COLV_W-1:0]   col_v;
  logic [ROWV_W-1:0]   row_v;
  logic                in_rng;
  logic [AW-1:0]       plot_addr, rd_addr;
  logic                ram_we;
  logic [AW-1:0]       ram_addr;
  logic                ram_wdata;
  logic                ram_rdata;

  // shared affine multiplier, one product a step
  always_comb begin
    unique case (cmd_i.step)
      STEP_BY: begin
        mul_coef = FERN_MAPS[map_q][K_B];
        mul_opnd = y_q;
      end
      STEP_CX: begin
        mul_coef = FERN_MAPS[map_q][K_C];
        mul_opnd = x_q;
      end
      STEP_DY: begin
        mul_coef = FERN_MAPS[map_q][K_D];
        mul_opnd = y_q;
      end
      default: begin
        mul_coef = FERN_MAPS[map_q][K_A];
        mul_opnd = x_q;
      end
    endcase
  end

  assign mul_p = PROD_W'(mul_coef) * PROD_W'(mul_opnd);
  assign sum   = SUM_W'(acc_q) + SUM_W'(prod_q);

  // scaling operands
  assign cx = (P_W+1)'(x_q) + COL_OFFSET;
  assign ry = ROW_TOP - (P_W+5)'(y_q) * Y_GAIN;

  // pixel position and bounds
  assign col_v  = c_mul_q[CM_W-1:REC_COL_SH];
  assign row_v  = r_mul_q[RM_W-1:REC_ROW_SH];
  assign in_rng = !c_neg_q && !r_neg_q &&
                  (col_v < COLV_W'(IMAGE_WIDTH)) && (row_v < ROWV_W'(IMAGE_HEIGHT));

  // row-major linear pixel index
  assign plot_addr = AW'(row_v) * AW'(IMAGE_WIDTH) + AW'(col_v);
  assign rd_addr   = AW'(rd_row_q) * AW'(IMAGE_WIDTH) + AW'(rd_col_q);

  // bitmap port: clearing sweep, plot write, or read
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = rd_addr;
    ram_wdata = 1'b0;
    if (cmd_i.clear) begin
      ram_we   = 1'b1;
      ram_addr = clr_cnt_q;
    end else if (cmd_i.step == STEP_PLOT) begin
      ram_we    = in_rng;
      ram_addr  = plot_addr;
      ram_wdata = 1'b1;
    end
  end

  assign clr_cnt_d           = cmd_i.clear ? clr_cnt_q + AW'(1) : clr_cnt_q;
  assign status_o.clear_last = (clr_cnt_q == AW'(DEPTH - 1));

  // item capture
  always_comb begin
    map_d    = map_q;
    rd_row_d = rd_row_q;
    rd_col_d = rd_col_q;
    rd_ok_d  = rd_ok_q;
    if (cmd_i.load) begin
      map_d    = pick_map(rand_value_i, thr_i);
      rd_row_d = read_row_i;
      rd_col_d = read_col_i;
      rd_ok_d  = (32'(read_row_i) < 32'(IMAGE_HEIGHT)) &&
                 (32'(read_col_i) < 32'(IMAGE_WIDTH));
    end
  end

  // step sequencing of the datapath registers
  always_comb begin
    x_d         = x_q;
    y_d         = y_q;
    nx_d        = nx_q;
    acc_d       = acc_q;
    prod_d      = prod_q;
    c_neg_d     = c_neg_q;
    r_neg_d     = r_neg_q;
    c_prod_d    = c_prod_q;
    r_prod_d    = r_prod_q;
    c_mul_d     = c_mul_q;
    r_mul_d     = r_mul_q;
    plot_col_d  = plot_col_q;
    plot_row_d  = plot_row_q;
    plotted_d   = plotted_q;
    pixel_bit_d = pixel_bit_q;
    unique case (cmd_i.step)
      STEP_AX: begin
        prod_d = mul_p;
      end
      STEP_BY: begin
        acc_d  = prod_q;
        prod_d = mul_p;
      end
      STEP_CX: begin
        nx_d   = round_sat(sum, FERN_MAPS[map_q][K_E]);
        prod_d = mul_p;
      end
      STEP_DY: begin
        acc_d  = prod_q;
        prod_d = mul_p;
      end
      STEP_NY: begin
        x_d = nx_q;
        y_d = round_sat(sum, FERN_MAPS[map_q][K_F]);
      end
      STEP_SCALE: begin
        c_neg_d  = cx[P_W];
        r_neg_d  = ry[P_W+4];
        c_prod_d = CPROD_W'(cx[P_W-1:0]) * CPROD_W'(IMAGE_WIDTH);
        r_prod_d = RPROD_W'(ry[P_W+2:0]) * RPROD_W'(IMAGE_HEIGHT);
      end
      STEP_DIV: begin
        c_mul_d = CM_W'(c_prod_q[CPROD_W-1:COL_PRE_SH]) * CM_W'(REC_COL);
        r_mul_d = RM_W'(r_prod_q[RPROD_W-1:ROW_PRE_SH]) * RM_W'(REC_ROW);
      end
      STEP_PLOT: begin
        plot_col_d  = in_rng ? col_v[7:0] : 8'd0;
        plot_row_d  = in_rng ? row_v[6:0] : 7'd0;
        plotted_d   = in_rng;
        pixel_bit_d = 1'b0;
      end
      STEP_RD_DATA: begin
        plot_col_d  = 8'd0;
        plot_row_d  = 7'd0;
        plotted_d   = 1'b0;
        pixel_bit_d = rd_ok_q & ram_rdata;
      end
      default: begin
      end
    endcase
  end

  // kept point and clearing counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q       <= '0;
      y_q       <= '0;
      clr_cnt_q <= '0;
    end else begin
      x_q       <= x_d;
      y_q       <= y_d;
      clr_cnt_q <= clr_cnt_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    nx_q        <= nx_d;
    acc_q       <= acc_d;
    prod_q      <= prod_d;
    map_q       <= map_d;
    rd_row_q    <= rd_row_d;
    rd_col_q    <= rd_col_d;
    rd_ok_q     <= rd_ok_d;
    c_neg_q     <= c_neg_d;
    r_neg_q     <= r_neg_d;
    c_prod_q    <= c_prod_d;
    r_prod_q    <= r_prod_d;
    c_mul_q     <= c_mul_d;
    r_mul_q     <= r_mul_d;
    plot_col_q  <= plot_col_d;
    plot_row_q  <= plot_row_d;
    plotted_q   <= plotted_d;
    pixel_bit_q <= pixel_bit_d;
  end

  ifs_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH)
  ) u_bitmap (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign plot_col_o  = plot_col_q;
  assign plot_row_o  = plot_row_q;
  assign plotted_o   = plotted_q;
  assign pixel_bit_o = pixel_bit_q;

endmodule

>>> src/ifs_fern_point_plotter_core.sv
// Barnsley fern plotter. Raise start with opcode_i = 0 to run one iteration
// (rand_value_i picks the map) or with opcode_i = 1 to read the bitmap bit
// at read_row_i / read_col_i; the item is taken at a clock edge where start
// is high and busy is low. Exactly one result beat follows each item,
// flagged by result_valid_o for a single cycle, and it must be taken then:
// there is no way to stall it. In an iteration one 18x24 multiplier makes
// four passes for the affine map, a fifth step rounds and saturates the new
// row coordinate, then one scaling stage, one reciprocal-multiply stage and
// the bitmap write follow, and a read spends its time in the registered
// bitmap port. A new item can be taken in the cycle its predecessor's result
// is shown. After reset the bitmap is swept clear one pixel a cycle, all
// IMAGE_WIDTH * IMAGE_HEIGHT pixels (32768 by default), with busy held high.
// Thresholds must be written by the user on the cfg port only while idle;
// the block does not enforce this. The port is always ready and ignores
// index 3.
module ifs_fern_point_plotter_core #(
  parameter int IMAGE_WIDTH  = 256,
  parameter int IMAGE_HEIGHT = 128
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic                              opcode_i,
  input  logic [6:0]                        rand_value_i,
  input  logic [6:0]                        read_row_i,
  input  logic [7:0]                        read_col_i,
  output logic                              result_valid_o,
  output logic [7:0]                        plot_col_o,
  output logic [6:0]                        plot_row_o,
  output logic                              plotted_o,
  output logic                              pixel_bit_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [ifs_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [6:0]                        cfg_data_i
);
  import ifs_pkg::*;

  ifs_thr_t    thr_q, thr_d;
  ifs_cmd_t    cmd;
  ifs_status_t status;

  assign cfg_ready_o = 1'b1;

  // threshold register writes
  always_comb begin
    thr_d = thr_q;
    if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_STEM:  thr_d.stem  = cfg_data_i;
        CFG_LEFT:  thr_d.left  = cfg_data_i;
        CFG_RIGHT: thr_d.right = cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q.stem  <= THR_STEM_RST;
      thr_q.left  <= THR_LEFT_RST;
      thr_q.right <= THR_RIGHT_RST;
    end else begin
      thr_q <= thr_d;
    end
  end

  ifs_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .opcode_i       (opcode_i),
    .busy_o         (busy),
    .result_valid_o (result_valid_o),
    .cmd_o          (cmd),
    .status_i       (status)
  );

  ifs_dp #(
    .IMAGE_WIDTH  (IMAGE_WIDTH),
    .IMAGE_HEIGHT (IMAGE_HEIGHT)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .thr_i        (thr_q),
    .rand_value_i (rand_value_i),
    .read_row_i   (read_row_i),
    .read_col_i   (read_col_i),
    .plot_col_o   (plot_col_o),
    .plot_row_o   (plot_row_o),
    .plotted_o    (plotted_o),
    .pixel_bit_o  (pixel_bit_o)
  );

endmodule
